// ===== design/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types and constants of the Gregorian date arithmetic unit.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 14;
  localparam int unsigned DiffW = 23;
  localparam int unsigned SerW  = 24;
  localparam int unsigned DoyW  = 26;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_SUB      = 3'd1,
    OP_DIFF     = 3'd2,
    OP_WEEKDAY  = 3'd3,
    OP_VALIDATE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DOY,
    S_ADDY,
    S_SUBY,
    S_MONTH,
    S_SER1,
    S_SER2,
    S_MOD,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic doy_step;
    logic addy_step;
    logic suby_step;
    logic month_step;
    logic ser_first;
    logic ser_second;
    logic mod_step;
    logic finish;
  } gda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    bad_op;
    logic    first_bad;
    logic    second_bad;
    logic    doy_done;
    logic    addy_done;
    logic    suby_done;
    logic    month_done;
    logic    mod_done;
    logic    range_err;
    op_t     op;
  } gda_stat_t;

  // Quotient by one hundred through a reciprocal multiplication, exact for
  // every 14-bit value.
  function automatic logic [YearW-1:0] div100(input logic [YearW-1:0] y);
    logic [26:0] prod;
    prod = 27'(y) * 27'd5243;
    return YearW'(prod[26:19]);
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] q;
    logic             cent;
    q    = div100(y);
    cent = (y == q * 14'd100);
    return ((y[1:0] == 2'd0) && !cent) || (cent && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/gda_ctrl.sv =====
// ----------------------------------------------------------------------------
// gda_ctrl
// Controller state machine that sequences the date datapath.
// ----------------------------------------------------------------------------
module gda_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  gda_pkg::gda_stat_t stat,
  output gda_pkg::gda_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);
  import gda_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad_op || stat.first_bad ||
            ((stat.op == OP_DIFF) && stat.second_bad)) begin
          state_nxt = S_DONE;
        end else if (stat.op == OP_VALIDATE) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DOY;
        end
      end
      S_DOY: begin
        cmd.doy_step = 1'b1;
        if (stat.doy_done) begin
          unique case (stat.op)
            OP_ADD:  state_nxt = S_ADDY;
            OP_SUB:  state_nxt = S_SUBY;
            default: state_nxt = S_SER1;
          endcase
        end
      end
      S_ADDY: begin
        cmd.addy_step = 1'b1;
        if (stat.range_err) begin
          state_nxt = S_DONE;
        end else if (stat.addy_done) begin
          state_nxt = S_MONTH;
        end
      end
      S_SUBY: begin
        cmd.suby_step = 1'b1;
        if (stat.range_err) begin
          state_nxt = S_DONE;
        end else if (stat.suby_done) begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd.month_step = 1'b1;
        if (stat.month_done) begin
          state_nxt = S_DONE;
        end
      end
      S_SER1: begin
        cmd.ser_first = 1'b1;
        state_nxt     = S_SER2;
      end
      S_SER2: begin
        cmd.ser_second = 1'b1;
        state_nxt      = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        out_valid  = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The result strobe is only raised when returning to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (state_r == S_IDLE))
    else $error("result strobe not followed by idle");
  // A transfer in is only taken from idle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy)
    else $error("load while busy");
  // Out of range only arises during the year walks; one met in the add walk must lead to the final state.
  a_range_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDY && stat.range_err) |=> (state_r == S_DONE))
    else $error("range error not reported");

endmodule

// ===== design/gda_dpath.sv =====
// ----------------------------------------------------------------------------
// gda_dpath
// Datapath of the date unit: month and year walks, serial day numbers and a
// digit-folding remainder by seven.
// ----------------------------------------------------------------------------
module gda_dpath #(
  parameter int unsigned YEAR_MIN   = 1600,
  parameter int unsigned YEAR_MAX   = 9999,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk,
  input  gda_pkg::gda_cmd_t              cmd,
  input  logic [2:0]                     in_opcode,
  input  logic [gda_pkg::DayW-1:0]       in_day,
  input  logic [gda_pkg::MonW-1:0]       in_month,
  input  logic [gda_pkg::YearW-1:0]      in_year,
  input  logic [COUNT_BITS-1:0]          in_day_count,
  input  logic [gda_pkg::DayW-1:0]       in_other_day,
  input  logic [gda_pkg::MonW-1:0]       in_other_month,
  input  logic [gda_pkg::YearW-1:0]      in_other_year,
  output gda_pkg::gda_stat_t             stat,
  output logic [gda_pkg::DayW-1:0]       out_result_day,
  output logic [gda_pkg::MonW-1:0]       out_result_month,
  output logic [gda_pkg::YearW-1:0]      out_result_year,
  output logic signed [gda_pkg::DiffW-1:0] out_day_difference,
  output logic [2:0]                     out_weekday,
  output logic [1:0]                     out_status
);
  import gda_pkg::*;

  localparam logic [YearW-1:0] YMin = YearW'(YEAR_MIN);
  localparam logic [YearW-1:0] YMax = YearW'(YEAR_MAX);
  // A multiple of seven that keeps the weekday offset positive for early years.
  localparam logic signed [SerW-1:0] WdBias = SerW'(7000);

  logic [2:0]              op_r;
  logic [DayW-1:0]         d_r, od_r;
  logic [MonW-1:0]         m_r, om_r;
  logic [YearW-1:0]        y_r, oy_r;
  logic [COUNT_BITS-1:0]   cnt_r;
  logic signed [DoyW-1:0]  doy_r, odoy_r;
  logic [MonW-1:0]         k_r;
  logic [YearW-1:0]        cy_r;
  logic signed [SerW-1:0]  s1_r, s2_r;
  logic signed [SerW-1:0]  v_r;
  logic                    rerr_r;

  logic [DayW-1:0]         rd_r;
  logic [MonW-1:0]         rm_r;
  logic [YearW-1:0]        ry_r;
  logic signed [DiffW-1:0] diff_r;
  logic [2:0]              wd_r;
  logic [1:0]              st_r;

  logic first_ok, second_ok, leap_y, leap_oy, leap_cy;
  logic [DayW-1:0] dim_k, dim_ok, dim_cm;
  logic [8:0] diy_cy;
  logic [YearW-1:0] cy_dec;
  logic [8:0] diy_dec;

  assign leap_y  = is_leap(y_r);
  assign leap_oy = is_leap(oy_r);
  assign leap_cy = is_leap(cy_r);
  assign cy_dec  = cy_r - 14'd1;
  assign diy_cy  = leap_cy ? 9'd366 : 9'd365;
  assign diy_dec = is_leap(cy_dec) ? 9'd366 : 9'd365;
  assign dim_k   = month_days(k_r, leap_y);
  assign dim_ok  = month_days(k_r, leap_oy);
  assign dim_cm  = month_days(k_r, leap_cy);

  assign first_ok = (y_r >= YMin) && (y_r <= YMax) && (m_r >= 4'd1) && (m_r <= 4'd12) &&
                    (d_r != 5'd0) && (d_r <= month_days(m_r, leap_y));
  assign second_ok = (oy_r >= YMin) && (oy_r <= YMax) && (om_r >= 4'd1) &&
                     (om_r <= 4'd12) && (od_r != 5'd0) &&
                     (od_r <= month_days(om_r, leap_oy));

  // Serial numbers of year starts; p = y - 1.
  function automatic logic signed [SerW-1:0] year_base(input logic [YearW-1:0] y);
    logic [YearW-1:0] p;
    logic [YearW-1:0] q;
    logic [SerW-1:0]  b;
    p = y - 14'd1;
    q = div100(p);
    b = SerW'(p) * 24'd365 + SerW'(p >> 2) - SerW'(q) + SerW'(q >> 2);
    return signed'(b);
  endfunction

  // Sum of octal digits; congruent to the argument modulo seven.
  function automatic logic [SerW-1:0] fold7(input logic [SerW-1:0] x);
    logic [SerW-1:0] s;
    s = '0;
    for (int i = 0; i < SerW / 3; i++) begin
      s = s + SerW'(x[3*i +: 3]);
    end
    return s;
  endfunction

  always_comb begin
    stat            = '0;
    stat.op         = op_t'(op_r);
    stat.bad_op     = (op_r > OP_VALIDATE);
    stat.first_bad  = !first_ok;
    stat.second_bad = !second_ok;
    stat.doy_done   = (k_r >= m_r) && (k_r >= om_r);
    stat.addy_done  = !(doy_r > signed'(DoyW'(diy_cy)));
    stat.suby_done  = !(doy_r < signed'(DoyW'(1)));
    stat.month_done = !(doy_r > signed'(DoyW'(dim_cm)));
    stat.mod_done   = (v_r[SerW-1:3] == '0);
    stat.range_err  = rerr_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      d_r    <= in_day;
      m_r    <= in_month;
      y_r    <= in_year;
      cnt_r  <= in_day_count;
      od_r   <= in_other_day;
      om_r   <= in_other_month;
      oy_r   <= in_other_year;
      doy_r  <= DoyW'(in_day);
      odoy_r <= DoyW'(in_other_day);
      k_r    <= 4'd1;
      cy_r   <= in_year;
      rerr_r <= 1'b0;
      rd_r   <= '0;
      rm_r   <= '0;
      ry_r   <= '0;
      diff_r <= '0;
      wd_r   <= '0;
      st_r   <= '0;
    end
    if (cmd.doy_step) begin
      if (stat.doy_done) begin
        k_r <= 4'd1;
        if (op_r == OP_ADD) begin
          doy_r <= doy_r + signed'(DoyW'(cnt_r));
        end else if (op_r == OP_SUB) begin
          doy_r <= doy_r - signed'(DoyW'(cnt_r));
        end
      end else begin
        if (k_r < m_r) begin
          doy_r <= doy_r + signed'(DoyW'(dim_k));
        end
        if (k_r < om_r) begin
          odoy_r <= odoy_r + signed'(DoyW'(dim_ok));
        end
        k_r <= k_r + 4'd1;
      end
    end
    if (cmd.addy_step && !stat.addy_done && !rerr_r) begin
      doy_r <= doy_r - signed'(DoyW'(diy_cy));
      cy_r  <= cy_r + 14'd1;
      if (cy_r + 14'd1 > YMax) begin
        rerr_r <= 1'b1;
      end
    end
    if (cmd.suby_step && !stat.suby_done && !rerr_r) begin
      cy_r <= cy_dec;
      if (cy_dec < YMin) begin
        rerr_r <= 1'b1;
      end else begin
        doy_r <= doy_r + signed'(DoyW'(diy_dec));
      end
    end
    if (cmd.month_step && !stat.month_done) begin
      doy_r <= doy_r - signed'(DoyW'(dim_cm));
      k_r   <= k_r + 4'd1;
    end
    if (cmd.ser_first) begin
      s1_r <= year_base(y_r) + SerW'(doy_r);
      s2_r <= year_base(oy_r) + SerW'(odoy_r);
    end
    if (cmd.ser_second) begin
      if (op_r == OP_DIFF) begin
        v_r <= '0;
      end else begin
        v_r <= s1_r - year_base(14'd1600) - SerW'(1) + WdBias;
      end
    end
    if (cmd.mod_step && !stat.mod_done) begin
      v_r <= signed'(fold7(v_r));
    end
    if (cmd.finish) begin
      if (op_r > OP_VALIDATE || !first_ok || (op_r == OP_DIFF && !second_ok)) begin
        st_r <= ST_INVALID;
      end else if (rerr_r) begin
        st_r <= ST_RANGE;
      end else if (op_r == OP_ADD || op_r == OP_SUB) begin
        rd_r <= doy_r[DayW-1:0];
        rm_r <= k_r;
        ry_r <= cy_r;
      end else if (op_r == OP_DIFF) begin
        diff_r <= DiffW'(s2_r - s1_r);
      end else if (op_r == OP_WEEKDAY) begin
        wd_r <= (v_r[2:0] == 3'd7) ? 3'd0 : v_r[2:0];
      end
    end
  end

  assign out_result_day     = rd_r;
  assign out_result_month   = rm_r;
  assign out_result_year    = ry_r;
  assign out_day_difference = diff_r;
  assign out_weekday        = wd_r;
  assign out_status         = st_r;

endmodule

// ===== design/gregorian_date_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit_core
// Gregorian date add, subtract, difference, weekday and validation unit.
// ----------------------------------------------------------------------------
// One item at a time: a transfer is taken when start is high and busy low.
// Busy then stays high for a check state, a month-sum walk over the months
// below the larger of the two month fields, the operation's own steps and a
// final state. Add and subtract step one year a cycle, then walk the months
// of the result; difference and weekday form serial day numbers in S_SER1
// and S_SER2 and then fold the remainder by seven. Validation and invalid
// items go from the check state straight to the final state. out_valid is
// high for a single cycle, the cycle in which busy falls, and the receiver
// cannot stall it.
module gregorian_date_arithmetic_unit_core #(
  parameter int unsigned YEAR_MIN   = 1600,
  parameter int unsigned YEAR_MAX   = 9999,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_opcode,
  input  logic [4:0]                    in_day,
  input  logic [3:0]                    in_month,
  input  logic [13:0]                   in_year,
  input  logic [COUNT_BITS-1:0]         in_day_count,
  input  logic [4:0]                    in_other_day,
  input  logic [3:0]                    in_other_month,
  input  logic [13:0]                   in_other_year,
  output logic                          out_valid,
  output logic [4:0]                    out_result_day,
  output logic [3:0]                    out_result_month,
  output logic [13:0]                   out_result_year,
  output logic signed [22:0]            out_day_difference,
  output logic [2:0]                    out_weekday,
  output logic [1:0]                    out_status
);
  import gda_pkg::*;

  gda_cmd_t  cmd;
  gda_stat_t stat;
  logic      fin_r;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (fin_r)
  );

  gda_dpath #(
    .YEAR_MIN   (YEAR_MIN),
    .YEAR_MAX   (YEAR_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk                (clk),
    .cmd                (cmd),
    .in_opcode          (in_opcode),
    .in_day             (in_day),
    .in_month           (in_month),
    .in_year            (in_year),
    .in_day_count       (in_day_count),
    .in_other_day       (in_other_day),
    .in_other_month     (in_other_month),
    .in_other_year      (in_other_year),
    .stat               (stat),
    .out_result_day     (out_result_day),
    .out_result_month   (out_result_month),
    .out_result_year    (out_result_year),
    .out_day_difference (out_day_difference),
    .out_weekday        (out_weekday),
    .out_status         (out_status)
  );

  logic valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= fin_r;
    end
  end

  assign out_valid = valid_r;

endmodule

// ===== dv/tb_gregorian_date_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// tb_gregorian_date_arithmetic_unit_core
// Self-checking testbench for the Gregorian date arithmetic unit. Directed and
// random items are sent in bursts with random gaps, each result is compared
// field by field with a predicted date, difference, weekday and status.
// ----------------------------------------------------------------------------
module tb_gregorian_date_arithmetic_unit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gda_pkg::*;

  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [22:0] diff;
    logic [2:0]  wday;
    logic [1:0]  status;
  } date_result_t;

  localparam int YearLo = 1600;
  localparam int YearHi = 9999;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  in_opcode = '0;
  logic [4:0]  in_day = '0;
  logic [3:0]  in_month = '0;
  logic [13:0] in_year = '0;
  logic [15:0] in_day_count = '0;
  logic [4:0]  in_other_day = '0;
  logic [3:0]  in_other_month = '0;
  logic [13:0] in_other_year = '0;
  logic out_valid;
  logic [4:0]  out_result_day;
  logic [3:0]  out_result_month;
  logic [13:0] out_result_year;
  logic signed [22:0] out_day_difference;
  logic [2:0]  out_weekday;
  logic [1:0]  out_status;

  date_result_t pending_dates[$];
  int fail_count = 0;
  int burst_left = 0;

  gregorian_date_arithmetic_unit_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int year_len(int y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int month_len(int m, int y);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit date_valid(int d, int m, int y);
    return y >= YearLo && y <= YearHi && m >= 1 && m <= 12 && d >= 1 &&
           d <= month_len(m, y);
  endfunction

  function automatic int ordinal_day(int d, int m, int y);
    int sum;
    sum = d;
    for (int k = 1; k < m; k++) sum += month_len(k, y);
    return sum;
  endfunction

  function automatic longint day_number(int d, int m, int y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400 + ordinal_day(d, m, y) - 1;
  endfunction

  function automatic date_result_t predict_date(logic [2:0] op, int d, int m, int y,
                                                int cnt, int od, int om, int oy);
    date_result_t r;
    longint doy;
    longint v;
    int cy;
    int cm;
    r = '{default: '0};
    if (op > OP_VALIDATE || !date_valid(d, m, y)) begin
      r.status = ST_INVALID;
    end else if (op == OP_ADD || op == OP_SUB) begin
      doy = ordinal_day(d, m, y);
      cy = y;
      if (op == OP_ADD) begin
        doy += cnt;
        while (r.status == ST_OK && doy > year_len(cy)) begin
          doy -= year_len(cy);
          cy++;
          if (cy > YearHi) r.status = ST_RANGE;
        end
      end else begin
        doy -= cnt;
        while (r.status == ST_OK && doy < 1) begin
          cy--;
          if (cy < YearLo) r.status = ST_RANGE;
          else doy += year_len(cy);
        end
      end
      if (r.status == ST_OK) begin
        cm = 1;
        while (doy > month_len(cm, cy)) begin
          doy -= month_len(cm, cy);
          cm++;
        end
        r.day = doy[4:0];
        r.month = cm[3:0];
        r.year = cy[13:0];
      end
    end else if (op == OP_DIFF) begin
      if (!date_valid(od, om, oy)) begin
        r.status = ST_INVALID;
      end else begin
        v = day_number(od, om, oy) - day_number(d, m, y);
        r.diff = v[22:0];
      end
    end else if (op == OP_WEEKDAY) begin
      v = (day_number(d, m, y) - day_number(1, 1, 1600)) % 7;
      if (v < 0) v += 7;
      r.wday = v[2:0];
    end
    return r;
  endfunction

  task automatic send_item(logic [2:0] op, logic [4:0] d, logic [3:0] m, logic [13:0] y,
                           logic [15:0] cnt, logic [4:0] od, logic [3:0] om,
                           logic [13:0] oy);
    in_opcode <= op;
    in_day <= d;
    in_month <= m;
    in_year <= y;
    in_day_count <= cnt;
    in_other_day <= od;
    in_other_month <= om;
    in_other_year <= oy;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_dates.push_back(predict_date(op, d, m, y, cnt, od, om, oy));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    date_result_t e;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        $error("result with no transfer outstanding");
        fail_count++;
      end else begin
        e = pending_dates.pop_front();
        if (out_result_day !== e.day) begin
          $error("result_day expected %0d got %0d", e.day, out_result_day);
          fail_count++;
        end
        if (out_result_month !== e.month) begin
          $error("result_month expected %0d got %0d", e.month, out_result_month);
          fail_count++;
        end
        if (out_result_year !== e.year) begin
          $error("result_year expected %0d got %0d", e.year, out_result_year);
          fail_count++;
        end
        if (out_day_difference !== e.diff) begin
          $error("day_difference expected %0d got %0d", $signed(e.diff),
                 out_day_difference);
          fail_count++;
        end
        if (out_weekday !== e.wday) begin
          $error("weekday expected %0d got %0d", e.wday, out_weekday);
          fail_count++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_status);
          fail_count++;
        end
      end
    end
  end

  task automatic random_date(int y_hi, output logic [4:0] d, output logic [3:0] m,
                             output logic [13:0] y);
    int yy;
    int mm;
    yy = ($urandom_range(0, 9) == 0) ? $urandom_range(YearLo, YearHi)
                                     : $urandom_range(YearLo, y_hi);
    mm = $urandom_range(1, 12);
    y = yy[13:0];
    m = mm[3:0];
    d = 5'($urandom_range(1, month_len(mm, yy)));
  endtask

  task automatic test_extremes;
    send_item(OP_VALIDATE, 5'd1, 4'd1, 14'd1600, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd31, 4'd12, 14'd9999, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd0, 4'd1, 14'd2000, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd31, 4'd4, 14'd2000, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd29, 4'd2, 14'd1900, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd29, 4'd2, 14'd2000, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd1, 4'd0, 14'd2000, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd1, 4'd13, 14'd2000, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd1, 4'd1, 14'd1599, '0, '0, '0, '0);
    send_item(OP_VALIDATE, 5'd31, 4'd15, 14'h3fff, 16'hffff, 5'h1f, 4'hf, 14'h3fff);
  endtask

  task automatic test_each_operation;
    for (int op = OP_VALIDATE + 1; op < 8; op++)
      send_item(op[2:0], 5'd1, 4'd1, 14'd2000, '0, '0, '0, '0);
    send_item(OP_ADD, 5'd28, 4'd2, 14'd2024, 16'd1, '0, '0, '0);
    send_item(OP_ADD, 5'd1, 4'd1, 14'd1600, 16'hffff, '0, '0, '0);
    send_item(OP_ADD, 5'd31, 4'd12, 14'd9999, 16'd1, '0, '0, '0);
    send_item(OP_ADD, 5'd31, 4'd12, 14'd9999, 16'd0, '0, '0, '0);
    send_item(OP_SUB, 5'd1, 4'd1, 14'd1600, 16'd1, '0, '0, '0);
    send_item(OP_SUB, 5'd1, 4'd3, 14'd2000, 16'd1, '0, '0, '0);
    send_item(OP_SUB, 5'd31, 4'd12, 14'd9999, 16'hffff, '0, '0, '0);
    send_item(OP_DIFF, 5'd1, 4'd1, 14'd1600, '0, 5'd31, 4'd12, 14'd9999);
    send_item(OP_DIFF, 5'd31, 4'd12, 14'd9999, '0, 5'd1, 4'd1, 14'd1600);
    send_item(OP_DIFF, 5'd1, 4'd1, 14'd2000, '0, 5'd30, 4'd2, 14'd2000);
    send_item(OP_WEEKDAY, 5'd1, 4'd1, 14'd1600, '0, '0, '0, '0);
    send_item(OP_WEEKDAY, 5'd31, 4'd12, 14'd9999, '0, '0, '0, '0);
    send_item(OP_WEEKDAY, 5'd15, 4'd6, 14'd1700, '0, '0, '0, '0);
  endtask

  task automatic test_random_items;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [4:0]  od;
    logic [3:0]  om;
    logic [13:0] oy;
    logic [2:0]  op;
    logic [15:0] cnt;
    for (int i = 0; i < 265; i++) begin
      op = 3'($urandom_range(OP_ADD, OP_VALIDATE));
      cnt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
      random_date(op == OP_WEEKDAY ? 1750 : 2400, d, m, y);
      random_date(2400, od, om, oy);
      if ($urandom_range(0, 4) == 0) begin
        op = 3'($urandom);
        d = 5'($urandom);
        m = 4'($urandom);
        y = ($urandom_range(0, 1) == 0) ? 14'($urandom) : 14'($urandom_range(1500, 1800));
        om = 4'($urandom);
        od = 5'($urandom);
        oy = 14'($urandom);
      end
      send_item(op, d, m, y, cnt, od, om, oy);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_each_operation();
    test_random_items();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gda_pkg.sv
design/gda_ctrl.sv
design/gda_dpath.sv
design/gregorian_date_arithmetic_unit_core.sv
dv/tb_gregorian_date_arithmetic_unit_core.sv
